/* hdl/brmp_pkg.sv */
// shared constants, command and status types for the binned region mean profile block
package brmp_pkg;

  localparam int MAX_BINS      = 64;
  localparam int BIN_W         = $clog2(MAX_BINS);
  localparam int CFG_W         = 7;
  localparam int DEPTH_W       = 24;
  localparam int LEN_W         = 24;
  localparam int SUM_W         = 48;
  localparam int CNT_W         = 24;
  localparam int MEAN_W        = 32;
  localparam int FRAC_W        = 8;
  localparam int BIN_COUNT_RST = 16;

  // shared restoring divider
  localparam int DIV_DW        = SUM_W + FRAC_W;
  localparam int DIV_VW        = 24;
  localparam int DIV_CNT_W     = $clog2(DIV_DW);

  typedef struct packed {
    logic region_start;
    logic sample_take;
    logic div_width_start;
    logic width_take;
    logic div_pos_start;
    logic pos_take;
    logic acc_read;
    logic acc_write;
    logic out_init;
    logic out_read;
    logic out_div_start;
    logic out_load;
  } brmp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic short_region;
    logic sample_last;
    logic entry_empty;
    logic last_bin;
    logic out_free;
  } brmp_sts_t;

endpackage

/* hdl/brmp_if.sv */
// valid/ready channel interfaces for samples, results and configuration
interface brmp_in_if import brmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth;
  logic               depth_valid;
  logic [LEN_W-1:0]   region_length;
  logic               reverse_strand;
  logic               last_sample;

  modport source (output valid, depth, depth_valid, region_length, reverse_strand,
                  last_sample, input ready);
  modport sink (input valid, depth, depth_valid, region_length, reverse_strand,
                last_sample, output ready);
endinterface

interface brmp_out_if import brmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BIN_W-1:0]  bin_index;
  logic [MEAN_W-1:0] bin_mean;
  logic              bin_empty;
  logic              last_bin;

  modport source (output valid, bin_index, bin_mean, bin_empty, last_bin, input ready);
  modport sink (input valid, bin_index, bin_mean, bin_empty, last_bin, output ready);
endinterface

interface brmp_cfg_if import brmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink (input valid, bin_count, output ready);
endinterface

/* hdl/brmp_div.sv */
// iterative restoring divider, one quotient bit per cycle
module brmp_div import brmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  output logic              done,
  output logic [DIV_DW-1:0] quot,
  output logic [DIV_VW-1:0] rem
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_DW - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DW-1:0]    quo_r;
  logic [DIV_VW-1:0]    rem_r;
  logic [DIV_VW-1:0]    dvs_r;
  logic [DIV_VW:0]      trial;
  logic [DIV_VW:0]      diff;
  logic                 fits;

  assign trial = {rem_r, quo_r[DIV_DW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      quo_r <= {quo_r[DIV_DW-2:0], fits};
      rem_r <= fits ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

/* hdl/brmp_datapath.sv */
// bin store, bin position tracking, accumulate, mean and result register
module brmp_datapath import brmp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  brmp_cmd_t          cmd,
  output brmp_sts_t          sts,
  input  logic [DEPTH_W-1:0] depth,
  input  logic               depth_valid,
  input  logic [LEN_W-1:0]   region_length,
  input  logic               reverse_strand,
  input  logic               last_sample,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [BIN_W-1:0]   bin_index,
  output logic [MEAN_W-1:0]  bin_mean,
  output logic               bin_empty,
  output logic               last_bin
);

  localparam int ENT_W = SUM_W + CNT_W;

  logic [CFG_W-1:0]   bin_count_r;
  logic [CFG_W-1:0]   eff_bins;
  logic [CFG_W-1:0]   nbins_r;
  logic [LEN_W-1:0]   len_r;
  logic               rev_r;
  logic [LEN_W-1:0]   width_r;
  logic [LEN_W-1:0]   pos_r;
  logic [BIN_W-1:0]   bin_r;
  logic [LEN_W-1:0]   off_r;
  logic [DEPTH_W-1:0] depth_r;
  logic               dvalid_r;
  logic               dlast_r;
  logic [BIN_W-1:0]   k_r;

  logic [ENT_W-1:0]    bin_mem_r [MAX_BINS];
  logic [MAX_BINS-1:0] entry_vld_r;
  logic [ENT_W-1:0]    rd_data_r;
  logic                rd_vld_r;
  logic [BIN_W-1:0]    rd_addr;

  logic [SUM_W-1:0]  rd_sum;
  logic [CNT_W-1:0]  rd_cnt;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              short_region;
  logic              pos_active;
  logic              empty;

  logic              div_start;
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_VW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_DW-1:0] div_quot;
  logic [DIV_VW-1:0] div_rem;
  logic [LEN_W:0]    ceil_num;

  logic              out_valid_r;
  logic [BIN_W-1:0]  bin_index_r;
  logic [MEAN_W-1:0] bin_mean_r;
  logic              bin_empty_r;
  logic              last_bin_r;

  // zero acts as one bin, anything above the store depth as the full depth
  always_comb begin
    if (bin_count_r == '0) begin
      eff_bins = CFG_W'(1);
    end else if (bin_count_r > CFG_W'(MAX_BINS)) begin
      eff_bins = CFG_W'(MAX_BINS);
    end else begin
      eff_bins = bin_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= CFG_W'(BIN_COUNT_RST);
    end else if (cfg_we) begin
      bin_count_r <= cfg_data;
    end
  end

  assign short_region = len_r < LEN_W'(nbins_r);
  assign pos_active   = pos_r < len_r;

  // divider operand selection
  assign ceil_num  = {1'b0, len_r} + (LEN_W+1)'(nbins_r) - (LEN_W+1)'(1);
  assign div_start = cmd.div_width_start | cmd.div_pos_start | cmd.out_div_start;

  always_comb begin
    priority if (cmd.div_width_start) begin
      div_dividend = DIV_DW'(ceil_num);
      div_divisor  = DIV_VW'(nbins_r);
    end else if (cmd.div_pos_start) begin
      div_dividend = DIV_DW'(len_r - LEN_W'(1));
      div_divisor  = width_r;
    end else begin
      div_dividend = {rd_sum, FRAC_W'(0)};
      div_divisor  = rd_cnt;
    end
  end

  brmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // region and sample registers, bin tracking
  always_ff @(posedge clk) begin
    if (cmd.region_start) begin
      len_r   <= region_length;
      rev_r   <= reverse_strand;
      nbins_r <= eff_bins;
      pos_r   <= '0;
    end
    if (cmd.sample_take) begin
      depth_r  <= depth;
      dvalid_r <= depth_valid;
      dlast_r  <= last_sample;
    end
    if (cmd.width_take) begin
      width_r <= div_quot[LEN_W-1:0];
    end
    if (cmd.pos_take) begin
      // reverse strand starts at the bin holding the region's last offset
      if (rev_r) begin
        bin_r <= div_quot[BIN_W-1:0];
        off_r <= div_rem;
      end else begin
        bin_r <= '0;
        off_r <= '0;
      end
    end
    if (cmd.acc_write && pos_active) begin
      pos_r <= pos_r + LEN_W'(1);
      if (rev_r) begin
        if (off_r == '0) begin
          bin_r <= bin_r - BIN_W'(1);
          off_r <= width_r - LEN_W'(1);
        end else begin
          off_r <= off_r - LEN_W'(1);
        end
      end else begin
        if (off_r == width_r - LEN_W'(1)) begin
          bin_r <= bin_r + BIN_W'(1);
          off_r <= '0;
        end else begin
          off_r <= off_r + LEN_W'(1);
        end
      end
    end
    if (cmd.out_init) begin
      k_r <= '0;
    end else if (cmd.out_load) begin
      k_r <= k_r + BIN_W'(1);
    end
  end

  // bin store: one read and one write port, registered read
  assign rd_addr = cmd.out_read ? k_r : bin_r;
  assign rd_sum  = rd_vld_r ? rd_data_r[ENT_W-1:CNT_W] : '0;
  assign rd_cnt  = rd_vld_r ? rd_data_r[CNT_W-1:0] : '0;
  assign sum_ext = {1'b0, rd_sum} + (SUM_W+1)'(depth_r);
  assign sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign cnt_nxt = (rd_cnt == '1) ? rd_cnt : rd_cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.acc_read || cmd.out_read) begin
      rd_data_r <= bin_mem_r[rd_addr];
      rd_vld_r  <= entry_vld_r[rd_addr];
    end
    if (cmd.acc_write && pos_active && !short_region && dvalid_r) begin
      bin_mem_r[bin_r] <= {sum_nxt, cnt_nxt};
    end
  end

  // entries not written since the region start read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
    end else if (cmd.region_start) begin
      entry_vld_r <= '0;
    end else if (cmd.acc_write && pos_active && !short_region && dvalid_r) begin
      entry_vld_r[bin_r] <= 1'b1;
    end
  end

  // result register
  assign empty = rd_cnt == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_index_r <= k_r;
      bin_empty_r <= empty;
      last_bin_r  <= sts.last_bin;
      if (empty) begin
        bin_mean_r <= '0;
      end else if (div_quot[DIV_DW-1:MEAN_W] != '0) begin
        bin_mean_r <= '1;
      end else begin
        bin_mean_r <= div_quot[MEAN_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign bin_index = bin_index_r;
  assign bin_mean  = bin_mean_r;
  assign bin_empty = bin_empty_r;
  assign last_bin  = last_bin_r;

  always_comb begin
    sts.div_done     = div_done;
    sts.short_region = short_region;
    sts.sample_last  = dlast_r;
    sts.entry_empty  = empty;
    sts.last_bin     = (CFG_W'(k_r) + CFG_W'(1)) == nbins_r;
    sts.out_free     = !out_valid_r || out_ready;
  end

endmodule

/* hdl/brmp_ctrl.sv */
// sequencer: region setup, sample accumulation and per-bin result walk
module brmp_ctrl import brmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  brmp_sts_t sts,
  output brmp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_W,
    ST_POS_ST,
    ST_DIV_P,
    ST_SAMPLE,
    ST_WRITE,
    ST_ACC,
    ST_OUT_RD,
    ST_OUT_ST,
    ST_OUT_DIV,
    ST_OUT_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.region_start = 1'b1;
          cmd.sample_take  = 1'b1;
          state_nxt        = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sts.short_region) begin
          state_nxt = ST_SAMPLE;
        end else begin
          cmd.div_width_start = 1'b1;
          state_nxt           = ST_DIV_W;
        end
      end
      ST_DIV_W: begin
        if (sts.div_done) begin
          cmd.width_take = 1'b1;
          state_nxt      = ST_POS_ST;
        end
      end
      ST_POS_ST: begin
        cmd.div_pos_start = 1'b1;
        state_nxt         = ST_DIV_P;
      end
      ST_DIV_P: begin
        if (sts.div_done) begin
          cmd.pos_take = 1'b1;
          state_nxt    = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        cmd.acc_read = 1'b1;
        state_nxt    = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.acc_write = 1'b1;
        if (!sts.sample_last) begin
          state_nxt = ST_ACC;
        end else if (sts.short_region) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.out_init = 1'b1;
          state_nxt    = ST_OUT_RD;
        end
      end
      ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.sample_take = 1'b1;
          cmd.acc_read    = 1'b1;
          state_nxt       = ST_WRITE;
        end
      end
      ST_OUT_RD: begin
        cmd.out_read = 1'b1;
        state_nxt    = ST_OUT_ST;
      end
      ST_OUT_ST: begin
        if (sts.entry_empty) begin
          state_nxt = ST_OUT_LOAD;
        end else begin
          cmd.out_div_start = 1'b1;
          state_nxt         = ST_OUT_DIV;
        end
      end
      ST_OUT_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT_LOAD;
        end
      end
      ST_OUT_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.last_bin ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/binned_region_mean_profile.sv */
// top level of the binned region mean profile block
//
// in_ch carries one depth sample per item; the first item of a region also
// gives region_length and reverse_strand, and the item with last_sample ends it.
// cfg_ch writes bin_count (0 acts as 1, above 64 as 64); it is latched at the
// first item of each region, so a write only matters between regions.
// out_ch returns one item per bin, bin 0 first, last_bin on the final one;
// a region shorter than its bin count returns nothing.
// steps: the first item of a region runs two divisions of 56 steps each on the
// shared divider (bin width, then the bin holding the last position); a short
// region skips both. each later item is a read then a write of the bin store.
// after the last item each bin is read from the store and, unless empty, its
// mean is formed on the same divider as sum*256/count.
// the bin store is cleared at each region start through per-bin valid bits,
// so there is no clearing pass. reset (rst_n low, synchronous) returns to the
// idle state, drops out valid and sets bin_count to 16.
// a stalled receiver holds the result register; the bin walk waits on it, and
// once the final bin is loaded the next region's items are taken again.
module binned_region_mean_profile import brmp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  brmp_in_if.sink   in_ch,
  brmp_out_if.source out_ch,
  brmp_cfg_if.sink  cfg_ch
);

  brmp_cmd_t cmd;
  brmp_sts_t sts;
  logic      in_ready;

  // configuration is always taken at once
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // controller sequences the datapath through command pulses
  brmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bin store, divider and result register
  brmp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .depth          (in_ch.depth),
    .depth_valid    (in_ch.depth_valid),
    .region_length  (in_ch.region_length),
    .reverse_strand (in_ch.reverse_strand),
    .last_sample    (in_ch.last_sample),
    .cfg_we         (cfg_ch.valid),
    .cfg_data       (cfg_ch.bin_count),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .bin_index      (out_ch.bin_index),
    .bin_mean       (out_ch.bin_mean),
    .bin_empty      (out_ch.bin_empty),
    .last_bin       (out_ch.last_bin)
  );

endmodule

/* tb/binned_region_mean_profile_tb.sv */
// self-checking testbench for the binned region mean profile block
`timescale 1ns / 1ps

module binned_region_mean_profile_tb;
  import brmp_pkg::*;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = '1;
  localparam logic [LEN_W-1:0]   LEN_MAX     = '1;
  localparam int                 RAND_ITEMS  = 120;
  localparam int                 IDLE_GAP    = 300;    // covers a region start and a bin divide
  localparam int                 QUIET_LIMIT = 10000;  // cycles with no handshake at all

  // one depth sample as it goes over the input channel
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               depth_valid;
    logic [LEN_W-1:0]   region_length;
    logic               reverse_strand;
    logic               last_sample;
  } sample_t;

  // one bin result as it comes back
  typedef struct packed {
    logic [BIN_W-1:0]  idx;
    logic [MEAN_W-1:0] mean;
    logic              empty;
    logic              last;
  } bin_result_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  // directed stimulus row: a bin count write or a sample, with an optional
  // hand-written expectation for single-bin or silent regions
  typedef struct {
    row_kind_t         kind;
    logic [CFG_W-1:0]  cfg;
    sample_t           s;
    bit                by_table;
    int                n_typed;
    logic [MEAN_W-1:0] t_mean;
    logic              t_empty;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  brmp_in_if  in_ch ();
  brmp_out_if out_ch ();
  brmp_cfg_if cfg_ch ();

  binned_region_mean_profile dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // profile predictor state, mirrors the block's bin store and region latches
  logic [SUM_W-1:0]  acc_sum [MAX_BINS];
  logic [CNT_W-1:0]  acc_cnt [MAX_BINS];
  logic [LEN_W-1:0]  pos_ctr;
  logic [LEN_W-1:0]  bin_w;
  logic [LEN_W-1:0]  rgn_len;
  logic              rgn_rev;
  logic              rgn_open;
  int                rgn_bins;
  logic [CFG_W-1:0]  bin_count_reg;

  bin_result_t region_bins[$];  // bins produced by the latest sample
  bin_result_t bins_due[$];     // bin results still owed by the block
  bin_result_t want;
  dir_row_t    dir_q[$];

  int sent;
  int fail_count;
  int quiet = 0;
  int rgn_no;
  bit calm;  // no idling on either side while set

  // bin count as the block uses it: 0 acts as 1, anything above 64 as 64
  function automatic int eff_bins(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_BINS) return MAX_BINS;
    return int'(v);
  endfunction

  // advance the profile by one accepted sample, leaving any bin results of a
  // finished region in region_bins
  function automatic void profile_sample(input sample_t s);
    longint unsigned off;
    longint unsigned b;
    longint unsigned m;
    logic [SUM_W:0]  sum_next;
    bit              short_rgn;
    bin_result_t     r;
    int              k;
    region_bins.delete();
    // first sample of a region: clear the bins and latch length, strand, count
    if (!rgn_open) begin
      for (k = 0; k < MAX_BINS; k++) begin
        acc_sum[k] = '0;
        acc_cnt[k] = '0;
      end
      pos_ctr  = '0;
      rgn_len  = s.region_length;
      rgn_rev  = s.reverse_strand;
      rgn_bins = eff_bins(bin_count_reg);
      bin_w    = LEN_W'((64'(rgn_len) + 64'(rgn_bins) - 1) / 64'(rgn_bins));
      rgn_open = 1'b1;
    end
    short_rgn = 64'(rgn_len) < 64'(rgn_bins);
    // samples past the region length only count for their end flag
    if (pos_ctr < rgn_len) begin
      if (!short_rgn && bin_w != 0 && s.depth_valid) begin
        off = rgn_rev ? 64'(rgn_len) - 64'(pos_ctr) - 1 : 64'(pos_ctr);
        b   = off / 64'(bin_w);
        if (b < MAX_BINS) begin
          sum_next   = {1'b0, acc_sum[b]} + (SUM_W + 1)'(s.depth);
          acc_sum[b] = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
          if (acc_cnt[b] != '1) acc_cnt[b] = acc_cnt[b] + 1'b1;
        end
      end
      pos_ctr = pos_ctr + 1'b1;
    end
    if (s.last_sample) begin
      rgn_open = 1'b0;
      if (!short_rgn) begin
        for (k = 0; k < rgn_bins; k++) begin
          r.idx  = BIN_W'(k);
          r.last = (k == rgn_bins - 1);
          if (acc_cnt[k] == 0) begin
            r.mean  = '0;
            r.empty = 1'b1;
          end else begin
            // 24.8 fixed point, truncated, clamped to 32 bits
            m       = 64'({acc_sum[k], {FRAC_W{1'b0}}}) / 64'(acc_cnt[k]);
            r.mean  = (m > 64'hFFFF_FFFF) ? '1 : m[MEAN_W-1:0];
            r.empty = 1'b0;
          end
          region_bins.push_back(r);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want_v, got_v);
  endtask

  function automatic dir_row_t known_row(input logic [DEPTH_W-1:0] d, input logic dv,
                                         input logic [LEN_W-1:0] len, input logic rev,
                                         input logic last, input int n,
                                         input logic [MEAN_W-1:0] mean, input logic empty);
    dir_row_t row;
    row.kind     = ROW_SAMPLE;
    row.cfg      = '0;
    row.s        = '{depth: d, depth_valid: dv, region_length: len,
                     reverse_strand: rev, last_sample: last};
    row.by_table = 1'b1;
    row.n_typed  = n;
    row.t_mean   = mean;
    row.t_empty  = empty;
    return row;
  endfunction

  function automatic dir_row_t smp_row(input logic [DEPTH_W-1:0] d, input logic dv,
                                       input logic [LEN_W-1:0] len, input logic rev,
                                       input logic last);
    dir_row_t row;
    row          = known_row(d, dv, len, rev, last, 0, '0, 1'b0);
    row.by_table = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_W-1:0] v);
    dir_row_t row;
    row          = known_row('0, 1'b0, '0, 1'b0, 1'b0, 0, '0, 1'b0);
    row.kind     = ROW_CFG;
    row.cfg      = v;
    row.by_table = 1'b0;
    return row;
  endfunction

  // offer one sample, wait for it to be taken, then book what it owes
  task automatic feed_sample(input sample_t s, input bit by_table, input int n_typed,
                             input logic [MEAN_W-1:0] t_mean, input logic t_empty);
    bin_result_t r;
    // occasional sender gap, never inside the calm window
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.depth          <= s.depth;
    in_ch.depth_valid    <= s.depth_valid;
    in_ch.region_length  <= s.region_length;
    in_ch.reverse_strand <= s.reverse_strand;
    in_ch.last_sample    <= s.last_sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    calm = (sent >= 60 && sent < 100);
    profile_sample(s);
    if (by_table) begin
      // hand-written expectation: either silence or bin 0 as the only bin
      if (n_typed == 1) begin
        r = '{idx: '0, mean: t_mean, empty: t_empty, last: 1'b1};
        bins_due.push_back(r);
      end
    end else begin
      foreach (region_bins[i]) bins_due.push_back(region_bins[i]);
    end
  endtask

  // sender holds off until every owed bin has come back
  task automatic wait_results();
    if (bins_due.size() != 0) begin
      in_ch.valid <= 1'b0;
      while (bins_due.size() != 0) @(posedge clk);
    end
  endtask

  // full quiet point: nothing owed and time for a silent region to finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic set_bin_count(input logic [CFG_W-1:0] v);
    settle();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.bin_count <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid  <= 1'b0;
    bin_count_reg = v;
  endtask

  // one random region sized around n bins; mostly well formed, with short,
  // huge, early-ended and over-long regions mixed in
  task automatic random_region(input int n);
    sample_t s;
    int      len;
    int      cnt;
    int      pick;
    int      i;
    pick             = $urandom_range(0, 9);
    s.reverse_strand = $urandom_range(0, 1);
    if (pick == 0) begin
      // short region, zero length included
      s.region_length = LEN_W'($urandom_range(0, n - 1));
      cnt             = $urandom_range(1, 3);
    end else if (pick == 1) begin
      // huge region cut short after a few samples
      s.region_length = LEN_W'($urandom_range(n, LEN_MAX));
      cnt             = $urandom_range(1, 6);
    end else begin
      len             = n * $urandom_range(1, 2) + $urandom_range(0, n - 1);
      s.region_length = LEN_W'(len);
      pick            = $urandom_range(0, 9);
      if (pick == 0) cnt = $urandom_range(1, len);
      else if (pick == 1) cnt = len + $urandom_range(1, 3);
      else cnt = len;
      if (cnt > 40) cnt = $urandom_range(1, 40);
    end
    for (i = 0; i < cnt; i++) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) s.depth = '0;
      else if (pick == 1) s.depth = DEPTH_MAX;
      else s.depth = DEPTH_W'($urandom_range(0, DEPTH_MAX));
      s.depth_valid = ($urandom_range(0, 9) < 8);
      s.last_sample = (i == cnt - 1);
      // length and strand only matter on the first sample; scramble the rest
      if (i != 0) begin
        s.region_length  = LEN_W'($urandom);
        s.reverse_strand = $urandom_range(0, 1);
      end
      feed_sample(s, 1'b0, 0, '0, 1'b0);
    end
  endtask

  // result side: random backpressure except in the calm window
  always @(posedge clk)
    out_ch.ready <= !rst_n ? 1'b0 : (calm || $urandom_range(0, 99) >= 10);

  // compare each returned bin against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (bins_due.size() == 0) begin
        report_mismatch("unexpected bin result, bin_index", 0, out_ch.bin_index);
      end else begin
        want = bins_due.pop_front();
        if (out_ch.bin_index !== want.idx) report_mismatch("bin_index", want.idx, out_ch.bin_index);
        if (out_ch.bin_mean !== want.mean) report_mismatch("bin_mean", want.mean, out_ch.bin_mean);
        if (out_ch.bin_empty !== want.empty)
          report_mismatch("bin_empty", want.empty, out_ch.bin_empty);
        if (out_ch.last_bin !== want.last) report_mismatch("last_bin", want.last, out_ch.last_bin);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("binned_region_mean_profile regression: fail");
    $finish;
  end

  initial begin
    int               phases;
    int               pick;
    logic [CFG_W-1:0] v;
    sent       = 0;
    fail_count = 0;
    rgn_no     = 0;
    calm       = 1'b0;
    // predictor at its reset state
    bin_count_reg = CFG_W'(BIN_COUNT_RST);
    rgn_open      = 1'b0;
    rgn_len       = '0;
    rgn_rev       = 1'b0;
    pos_ctr       = '0;
    bin_w         = '0;
    rgn_bins      = BIN_COUNT_RST;
    // every sender input known from time zero
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.depth          <= '0;
    in_ch.depth_valid    <= 1'b0;
    in_ch.region_length  <= '0;
    in_ch.reverse_strand <= 1'b0;
    in_ch.last_sample    <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.bin_count     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    // after reset the count is 16, so a 15-position region stays silent
    dir_q.push_back(known_row(24'd5, 1'b1, 24'd15, 1'b0, 1'b1, 0, '0, 1'b0));
    // a count of 0 acts as one bin
    dir_q.push_back(cfg_row(7'd0));
    dir_q.push_back(known_row(DEPTH_MAX, 1'b1, 24'd1, 1'b0, 1'b1, 1, 32'hFFFF_FF00, 1'b0));
    // missing depth on a reverse region leaves the bin empty
    dir_q.push_back(known_row(DEPTH_MAX, 1'b0, 24'd1, 1'b1, 1'b1, 1, 32'h0, 1'b1));
    // zero length is a short region
    dir_q.push_back(known_row(24'd3, 1'b1, 24'd0, 1'b0, 1'b1, 0, '0, 1'b0));
    // two positions, then two excess samples whose end flag still closes it
    dir_q.push_back(smp_row(24'd7, 1'b1, 24'd2, 1'b0, 1'b0));
    dir_q.push_back(smp_row(DEPTH_MAX, 1'b1, LEN_MAX, 1'b1, 1'b0));
    dir_q.push_back(smp_row(24'd9, 1'b1, 24'd0, 1'b0, 1'b0));
    dir_q.push_back(smp_row(24'd0, 1'b0, 24'd0, 1'b0, 1'b1));
    // count above the maximum acts as 64; reverse region ended early
    dir_q.push_back(cfg_row(7'd127));
    dir_q.push_back(smp_row(24'd100, 1'b1, 24'd64, 1'b1, 1'b0));
    dir_q.push_back(smp_row(24'd200, 1'b1, 24'd0, 1'b0, 1'b0));
    dir_q.push_back(smp_row(24'd50, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_q.push_back(smp_row(DEPTH_MAX, 1'b1, 24'd0, 1'b0, 1'b1));
    // short region under 64 bins
    dir_q.push_back(smp_row(24'd1, 1'b1, 24'd10, 1'b0, 1'b0));
    dir_q.push_back(known_row(24'd2, 1'b1, 24'd0, 1'b0, 1'b1, 0, '0, 1'b0));
    // three bins over five positions, last bin narrower
    dir_q.push_back(cfg_row(7'd3));
    dir_q.push_back(smp_row(24'd10, 1'b1, 24'd5, 1'b0, 1'b0));
    dir_q.push_back(smp_row(24'd20, 1'b1, 24'd0, 1'b0, 1'b0));
    dir_q.push_back(smp_row(24'd0, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_q.push_back(smp_row(24'd30, 1'b1, 24'd0, 1'b0, 1'b0));
    dir_q.push_back(smp_row(DEPTH_MAX, 1'b1, 24'd0, 1'b0, 1'b1));
    // longest region, reverse, cut after two samples
    dir_q.push_back(cfg_row(7'd64));
    dir_q.push_back(smp_row(DEPTH_MAX, 1'b1, LEN_MAX, 1'b1, 1'b0));
    dir_q.push_back(smp_row(24'd1, 1'b1, 24'd0, 1'b0, 1'b1));
    // two bins, reverse, three positions
    dir_q.push_back(cfg_row(7'd2));
    dir_q.push_back(smp_row(24'd4, 1'b1, 24'd3, 1'b1, 1'b0));
    dir_q.push_back(smp_row(24'd5, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_q.push_back(smp_row(24'd6, 1'b1, 24'd0, 1'b0, 1'b1));

    foreach (dir_q[i]) begin
      if (dir_q[i].kind == ROW_CFG)
        set_bin_count(dir_q[i].cfg);
      else
        feed_sample(dir_q[i].s, dir_q[i].by_table, dir_q[i].n_typed,
                    dir_q[i].t_mean, dir_q[i].t_empty);
    end

    // random part: phases of one bin count each, a few regions per phase
    phases = sent + RAND_ITEMS;
    while (sent < phases) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) v = '0;
      else if (pick == 1) v = CFG_W'(MAX_BINS);
      else if (pick == 2) v = CFG_W'($urandom_range(MAX_BINS + 1, 127));
      else if (pick == 3) v = CFG_W'($urandom_range(9, MAX_BINS - 1));
      else v = CFG_W'($urandom_range(1, 8));
      set_bin_count(v);
      repeat ($urandom_range(2, 4)) begin
        if (sent < phases) begin
          // sender sometimes waits for the whole backlog to drain
          if (rgn_no == 3 || $urandom_range(0, 7) == 0) wait_results();
          random_region(eff_bins(v));
          rgn_no++;
        end
      end
    end

    settle();
    if (fail_count == 0 && bins_due.size() == 0)
      $display("binned_region_mean_profile regression: pass");
    else
      $display("binned_region_mean_profile regression: fail");
    $finish;
  end

endmodule

/* sim.f */
hdl/brmp_pkg.sv
hdl/brmp_if.sv
hdl/brmp_div.sv
hdl/brmp_datapath.sv
hdl/brmp_ctrl.sv
hdl/binned_region_mean_profile.sv
tb/binned_region_mean_profile_tb.sv
